// File: hdl/sefr_pkg.sv
// Shared types, codes and CRC functions of the escaped frame receiver.
package sefr_pkg;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_CMD,
        PH_SIZE,
        PH_HCRC,
        PH_DATA,
        PH_DCRC_HI,
        PH_DCRC_LO,
        PH_SYNC_OR_CMD
    } phase_t;

    localparam logic [1:0] EV_PAYLOAD = 2'd0;
    localparam logic [1:0] EV_GOOD    = 2'd1;
    localparam logic [1:0] EV_ERROR   = 2'd2;

    localparam logic [1:0] ERR_BAD_CMD = 2'd0;
    localparam logic [1:0] ERR_HDR_CRC = 2'd1;
    localparam logic [1:0] ERR_DAT_CRC = 2'd2;

    localparam logic REG_SYNC_VALUE = 1'b0;
    localparam logic REG_HDR_POLY   = 1'b1;

    localparam logic [7:0]  SYNC_RESET = 8'hA6;
    localparam logic [7:0]  POLY_RESET = 8'h07;
    localparam logic [7:0]  CRC8_INIT  = 8'h00;
    localparam logic [15:0] CRC16_INIT = 16'hFFFF;
    localparam logic [15:0] CRC16_POLY = 16'h1021;

    typedef struct packed {
        logic [7:0] sync_value;
        logic [7:0] header_crc_poly;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  event_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  byte_index;
        logic [6:0]  command_code;
        logic        ack_wanted;
        logic [7:0]  frame_length;
        logic [1:0]  error_cause;
        logic [15:0] errors_seen;
    } result_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] b, input logic [7:0] c,
                                               input logic [7:0] poly);
        logic [7:0] v;
        v = c ^ b;
        for (int i = 0; i < 8; i++) begin
            v = v[7] ? ({v[6:0], 1'b0} ^ poly) : {v[6:0], 1'b0};
        end
        return v;
    endfunction

    function automatic logic [15:0] crc16_update(input logic [7:0] b, input logic [15:0] c);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            v = v[15] ? ({v[14:0], 1'b0} ^ CRC16_POLY) : {v[14:0], 1'b0};
        end
        return v;
    endfunction

endpackage

// File: hdl/sync_escaped_frame_receiver_core.sv
// Top level of the sync-byte escaped frame receiver with CRC-8/CRC-16 checks.
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   s_tdata: rx_byte
//  m_*       out  m_tvalid/m_tready   m_tuser: event_kind, m_tdata: result fields
//  cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte per cycle sustained while m_* is not stalled.
// A byte sits in the input register, then one pass of the parser (two byte-wide
// CRC updates and the phase step) loads the result register.
// Stalls on m_* hold the result register and back-pressure s_* through the input
// register. Reset clears phase, CRCs, counters and restores the register defaults.
module sync_escaped_frame_receiver_core
    import sefr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [7:0] payload_byte, [15:8] byte_index,
                                    // [22:16] command_code, [23] ack_wanted,
                                    // [31:24] frame_length, [33:32] error_cause,
                                    // [49:34] errors_seen, [55:50] zero
    output logic [1:0]  m_tuser,    // [1:0] event_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    result;
    logic       advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_value      <= SYNC_RESET;
            cfg_reg.header_crc_poly <= POLY_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SYNC_VALUE: cfg_reg.sync_value      <= cfg_data;
                REG_HDR_POLY:   cfg_reg.header_crc_poly <= cfg_data;
                default:        cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= result.valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance && result.valid)
        begin
            out_reg <= result;
        end
    end

    sefr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_kind;
    assign m_tdata  = {6'd0, out_reg.errors_seen, out_reg.error_cause, out_reg.frame_length,
                       out_reg.ack_wanted, out_reg.command_code, out_reg.byte_index,
                       out_reg.payload_byte};

endmodule

// File: hdl/sefr_parser.sv
// Frame phase tracking, CRC update and event generation for one byte.
module sefr_parser
    import sefr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output result_t    result
);

    phase_t      phase_reg, phase_next;
    phase_t      resume_reg, resume_next;
    logic [7:0]  hcrc_reg, hcrc_next;
    logic [15:0] fcrc_reg, fcrc_next;
    logic [6:0]  cmd_reg, cmd_next;
    logic        ack_reg, ack_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  taken_reg, taken_next;
    logic [15:0] tally_reg, tally_next;

    logic        is_sync;
    logic        esc_enter;
    logic        restart;
    phase_t      run_phase;
    logic [7:0]  hcrc_base;
    logic [15:0] fcrc_base;
    logic [7:0]  taken_base;
    logic [7:0]  hcrc_upd;
    logic [15:0] fcrc_upd;
    logic        cmd_ok;
    logic        hcrc_bad;
    logic        more_data;

    assign is_sync   = (rx_byte == cfg.sync_value);
    assign esc_enter = is_sync && (phase_reg != PH_WAIT) && (phase_reg != PH_CMD)
                       && (phase_reg != PH_SYNC_OR_CMD);

    always_comb
    begin
        if (phase_reg == PH_SYNC_OR_CMD)
        begin
            run_phase = is_sync ? resume_reg : PH_CMD;
        end
        else
        begin
            run_phase = phase_reg;
        end
    end

    assign restart = ((phase_reg == PH_SYNC_OR_CMD) && !is_sync)
                     || ((phase_reg == PH_WAIT) && is_sync);

    assign hcrc_base  = restart ? crc8_update(cfg.sync_value, CRC8_INIT, cfg.header_crc_poly)
                                : hcrc_reg;
    assign fcrc_base  = restart ? crc16_update(cfg.sync_value, CRC16_INIT) : fcrc_reg;
    assign taken_base = restart ? 8'h00 : taken_reg;

    assign hcrc_upd  = crc8_update(rx_byte, hcrc_base, cfg.header_crc_poly);
    assign fcrc_upd  = crc16_update(rx_byte, fcrc_base);
    assign cmd_ok    = (rx_byte[6:0] != 7'd0);
    assign hcrc_bad  = (hcrc_base != rx_byte);
    assign more_data = ({1'b0, taken_base} + 9'd1) < {1'b0, len_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        resume_next = resume_reg;
        if (step)
        begin
            if (esc_enter)
            begin
                resume_next = phase_reg;
                phase_next  = PH_SYNC_OR_CMD;
            end
            else
            begin
                case (run_phase)
                    PH_CMD:     phase_next = cmd_ok ? PH_SIZE : PH_WAIT;
                    PH_SIZE:    phase_next = PH_HCRC;
                    PH_HCRC:    phase_next = (hcrc_bad || (len_reg == 8'd0)) ? PH_WAIT : PH_DATA;
                    PH_DATA:    phase_next = more_data ? PH_DATA : PH_DCRC_HI;
                    PH_DCRC_HI: phase_next = (rx_byte != fcrc_base[15:8]) ? PH_WAIT : PH_DCRC_LO;
                    PH_DCRC_LO: phase_next = PH_WAIT;
                    default:    phase_next = is_sync ? PH_CMD : PH_WAIT;
                endcase
            end
        end
    end

    always_comb
    begin
        hcrc_next  = hcrc_reg;
        fcrc_next  = fcrc_reg;
        cmd_next   = cmd_reg;
        ack_next   = ack_reg;
        len_next   = len_reg;
        taken_next = taken_reg;
        tally_next = tally_reg;
        result     = '0;
        if (step && !esc_enter)
        begin
            hcrc_next  = hcrc_base;
            fcrc_next  = fcrc_base;
            taken_next = taken_base;
            case (run_phase)
                PH_CMD:
                begin
                    if (cmd_ok)
                    begin
                        hcrc_next = hcrc_upd;
                        fcrc_next = fcrc_upd;
                        cmd_next  = rx_byte[6:0];
                        ack_next  = rx_byte[7];
                    end
                    else
                    begin
                        tally_next         = tally_reg + 16'd1;
                        result.valid       = 1'b1;
                        result.event_kind  = EV_ERROR;
                        result.error_cause = ERR_BAD_CMD;
                    end
                end
                PH_SIZE:
                begin
                    hcrc_next = hcrc_upd;
                    fcrc_next = fcrc_upd;
                    len_next  = rx_byte;
                end
                PH_HCRC:
                begin
                    if (hcrc_bad)
                    begin
                        tally_next         = tally_reg + 16'd1;
                        result.valid       = 1'b1;
                        result.event_kind  = EV_ERROR;
                        result.error_cause = ERR_HDR_CRC;
                    end
                    else if (len_reg == 8'd0)
                    begin
                        result.valid        = 1'b1;
                        result.event_kind   = EV_GOOD;
                        result.command_code = cmd_reg;
                        result.ack_wanted   = ack_reg;
                        result.frame_length = len_reg;
                    end
                    else
                    begin
                        fcrc_next = fcrc_upd;
                    end
                end
                PH_DATA:
                begin
                    fcrc_next           = fcrc_upd;
                    taken_next          = taken_base + 8'd1;
                    result.valid        = 1'b1;
                    result.event_kind   = EV_PAYLOAD;
                    result.payload_byte = rx_byte;
                    result.byte_index   = taken_base;
                end
                PH_DCRC_HI:
                begin
                    if (rx_byte != fcrc_base[15:8])
                    begin
                        tally_next         = tally_reg + 16'd1;
                        result.valid       = 1'b1;
                        result.event_kind  = EV_ERROR;
                        result.error_cause = ERR_DAT_CRC;
                    end
                end
                PH_DCRC_LO:
                begin
                    result.valid = 1'b1;
                    if (rx_byte != fcrc_base[7:0])
                    begin
                        tally_next         = tally_reg + 16'd1;
                        result.event_kind  = EV_ERROR;
                        result.error_cause = ERR_DAT_CRC;
                    end
                    else
                    begin
                        result.event_kind   = EV_GOOD;
                        result.command_code = cmd_reg;
                        result.ack_wanted   = ack_reg;
                        result.frame_length = len_reg;
                    end
                end
                default:
                begin
                end
            endcase
            result.errors_seen = tally_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            resume_reg <= PH_WAIT;
            hcrc_reg   <= CRC8_INIT;
            fcrc_reg   <= CRC16_INIT;
            cmd_reg    <= 7'd0;
            ack_reg    <= 1'b0;
            len_reg    <= 8'd0;
            taken_reg  <= 8'd0;
            tally_reg  <= 16'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            resume_reg <= resume_next;
            hcrc_reg   <= hcrc_next;
            fcrc_reg   <= fcrc_next;
            cmd_reg    <= cmd_next;
            ack_reg    <= ack_next;
            len_reg    <= len_next;
            taken_reg  <= taken_next;
            tally_reg  <= tally_next;
        end
    end

endmodule
